// ===== design/assert_macros.svh =====
// Assertion macros shared by the tuple enumerator RTL.
// Expect aclk and aresetn in the scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TENUM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TENUM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tenum_pkg.sv =====
// Shared types and constants for the tuple enumerator.
// No dependencies; imported by tenum_step and tuple_enumerator_core.
package tenum_pkg;

    localparam int VAL_W     = 5;
    localparam int POS_W     = 4;
    localparam int CMP_W     = VAL_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_N_ITEMS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TUPLE_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd2;

    typedef enum logic [1:0] {
        MODE_PERM     = 2'd0,
        MODE_PERM_REP = 2'd1,
        MODE_COMB     = 2'd2,
        MODE_COMB_REP = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  scan;
    } tenum_ctl_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value;
    } tenum_res_t;

endpackage

// ===== design/tenum_step.sv =====
// Shared step unit: one compare/add and one lowest-free-value search per cycle.
// Depends on tenum_pkg.
module tenum_step import tenum_pkg::*; #(
    parameter int MAX_ELEMS = 16
) (
    input  tenum_ctl_t           ctl,
    input  logic [VAL_W-1:0]     t,
    input  logic [VAL_W-1:0]     n_eff,
    input  logic [VAL_W-1:0]     r_last,
    input  logic [CMP_W-1:0]     ptr,
    input  logic [VAL_W-1:0]     base,
    input  logic [MAX_ELEMS-1:0] used,
    output tenum_res_t           res,
    output logic [MAX_ELEMS-1:0] used_out
);

    logic [MAX_ELEMS-1:0] used_c;
    logic [MAX_ELEMS-1:0] range_mask;
    logic [MAX_ELEMS-1:0] cand;
    logic [MAX_ELEMS-1:0] pick_bit;
    logic [VAL_W-1:0]     lo;
    logic [VAL_W-1:0]     pick;
    logic                 found;
    logic [VAL_W-1:0]     t_inc;
    logic [CMP_W-1:0]     span;
    logic                 t_below_n;

    always_comb begin
        lo = ctl.scan ? t : '0;
        for (int k = 0; k < MAX_ELEMS; k++) begin
            used_c[k] = used[k] & ~(ctl.scan && (CMP_W'(k + 1) == {1'b0, t}));
            range_mask[k] = (CMP_W'(k) >= {1'b0, lo}) && (CMP_W'(k) < {1'b0, n_eff});
        end
        cand  = ~used_c & range_mask;
        found = |cand;
        pick  = '0;
        for (int k = MAX_ELEMS - 1; k >= 0; k--) begin
            if (cand[k]) begin
                pick = VAL_W'(k + 1);
            end
        end
        for (int k = 0; k < MAX_ELEMS; k++) begin
            pick_bit[k] = found && (CMP_W'(k + 1) == {1'b0, pick});
        end
    end

    assign t_inc     = t + 1'b1;
    assign span      = {1'b0, t} + ({1'b0, r_last} - ptr);
    assign t_below_n = t < n_eff;

    always_comb begin
        used_out = used;
        case (ctl.mode)
            MODE_PERM: begin
                res.hit   = found;
                res.value = pick;
                used_out  = used_c | pick_bit;
            end
            MODE_PERM_REP: begin
                res.hit   = t_below_n;
                res.value = ctl.scan ? t_inc : VAL_W'(1);
            end
            MODE_COMB: begin
                res.hit   = span < {1'b0, n_eff};
                res.value = ctl.scan ? t_inc : base + 1'b1;
            end
            MODE_COMB_REP: begin
                res.hit   = t_below_n;
                res.value = ctl.scan ? t_inc : base;
            end
            default: begin
                res.hit   = 1'b0;
                res.value = '0;
            end
        endcase
    end

endmodule

// ===== design/tuple_enumerator_core.sv =====
// Top level of the tuple enumerator: sequencer, tuple store and output register.
// Depends on tenum_pkg, tenum_step and assert_macros.svh.
//
// Usage: set n_items (index 0), tuple_len (index 1) and mode (index 2) through
// the cfg_* write channel while the block is idle; any register write ends the
// enumeration in progress. Each transfer on the s_* channel is one request:
// s_restart high starts over and yields the first tuple, low yields the next.
// Each request returns tuple_len transfers (at most MAX_ELEMS) on m_*, one
// element each, with m_last on the final one, or a single transfer with
// m_exhausted set once no tuple remains.
// A restart goes straight to emitting r elements (r = tuple length). An
// advance scans from the right one position per cycle through the shared step
// unit, refills the positions to the right of the pivot one per cycle, then
// emits r elements. An exhausted answer is a single transfer, also when an
// advance scan finds no pivot.
// s_ready is high only between requests.
// Reset restores n_items=4, tuple_len=2, mode=0 and clears any enumeration.
// A stalled m_ready holds the output register and pauses the sequencer in its emit and exhausted states.
`include "assert_macros.svh"

module tuple_enumerator_core import tenum_pkg::*; #(
    parameter int MAX_ELEMS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_restart,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [VAL_W-1:0]     m_element,
    output logic [POS_W-1:0]     m_position,
    output logic                 m_last,
    output logic                 m_exhausted
);

    localparam int IW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_FILL = 5'b00100,
        ST_EMIT = 5'b01000,
        ST_EXH  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [VAL_W-1:0]     n_items_reg, n_items_next;
    logic [VAL_W-1:0]     tuple_len_reg, tuple_len_next;
    mode_t                mode_reg, mode_next;
    logic                 started_reg, started_next;
    logic                 finished_reg, finished_next;
    logic [VAL_W-1:0]     tuple_reg [MAX_ELEMS];
    logic [VAL_W-1:0]     tuple_next [MAX_ELEMS];
    logic [MAX_ELEMS-1:0] used_reg, used_next;
    logic [IW-1:0]        ptr_reg, ptr_next;
    logic [VAL_W-1:0]     base_reg, base_next;
    logic                 m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]     m_element_reg, m_element_next;
    logic [POS_W-1:0]     m_position_reg, m_position_next;
    logic                 m_last_reg, m_last_next;
    logic                 m_exhausted_reg, m_exhausted_next;

    logic [VAL_W-1:0]     n_eff;
    logic [VAL_W-1:0]     r_eff;
    logic [VAL_W-1:0]     r_last;
    logic                 at_last;
    logic                 first_ok;
    logic                 ascending;
    logic                 out_free;
    logic                 s_fire;
    tenum_ctl_t           step_ctl;
    tenum_res_t           step_res;
    logic [MAX_ELEMS-1:0] step_used;
    logic                 exh_beat;
    logic                 exh_ok;
    logic                 elem_beat;
    logic                 adv_exh;

    assign n_eff = ({1'b0, n_items_reg} > CMP_W'(MAX_ELEMS)) ? VAL_W'(MAX_ELEMS) : n_items_reg;
    assign r_eff = ({1'b0, tuple_len_reg} > CMP_W'(MAX_ELEMS)) ? VAL_W'(MAX_ELEMS)
                                                                : tuple_len_reg;
    assign r_last    = r_eff - 1'b1;
    assign at_last   = CMP_W'(ptr_reg) == {1'b0, r_last};
    assign ascending = (mode_reg == MODE_PERM) || (mode_reg == MODE_COMB);
    assign first_ok  = (n_eff != '0) && (r_eff != '0) && !(ascending && (r_eff > n_eff));

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = state_reg == ST_IDLE;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign step_ctl.mode = mode_reg;
    assign step_ctl.scan = state_reg == ST_SCAN;

    tenum_step #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_step (
        .ctl      (step_ctl),
        .t        (tuple_reg[ptr_reg]),
        .n_eff    (n_eff),
        .r_last   (r_last),
        .ptr      (CMP_W'(ptr_reg)),
        .base     (base_reg),
        .used     (used_reg),
        .res      (step_res),
        .used_out (step_used)
    );

    always_comb begin
        state_next       = state_reg;
        n_items_next     = n_items_reg;
        tuple_len_next   = tuple_len_reg;
        mode_next        = mode_reg;
        started_next     = started_reg;
        finished_next    = finished_reg;
        tuple_next       = tuple_reg;
        used_next        = used_reg;
        ptr_next         = ptr_reg;
        base_next        = base_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_element_next   = m_element_reg;
        m_position_next  = m_position_reg;
        m_last_next      = m_last_reg;
        m_exhausted_next = m_exhausted_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_restart || !started_reg) begin
                        started_next = 1'b1;
                        if (first_ok) begin
                            for (int j = 0; j < MAX_ELEMS; j++) begin
                                if (CMP_W'(j) < {1'b0, r_eff}) begin
                                    tuple_next[j] = ascending ? VAL_W'(j + 1) : VAL_W'(1);
                                end else begin
                                    tuple_next[j] = '0;
                                end
                                used_next[j] = (mode_reg == MODE_PERM) &&
                                               (CMP_W'(j) < {1'b0, r_eff});
                            end
                            finished_next = 1'b0;
                            ptr_next      = '0;
                            state_next    = ST_EMIT;
                        end else begin
                            finished_next = 1'b1;
                            state_next    = ST_EXH;
                        end
                    end else if (finished_reg) begin
                        state_next = ST_EXH;
                    end else begin
                        ptr_next   = IW'(r_last);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                used_next = step_used;
                if (step_res.hit) begin
                    tuple_next[ptr_reg] = step_res.value;
                    base_next           = step_res.value;
                    if (at_last) begin
                        ptr_next   = '0;
                        state_next = ST_EMIT;
                    end else begin
                        ptr_next   = ptr_reg + 1'b1;
                        state_next = ST_FILL;
                    end
                end else if (ptr_reg == '0) begin
                    finished_next = 1'b1;
                    state_next    = ST_EXH;
                end else begin
                    ptr_next = ptr_reg - 1'b1;
                end
            end
            ST_FILL: begin
                used_next           = step_used;
                tuple_next[ptr_reg] = step_res.value;
                base_next           = step_res.value;
                if (at_last) begin
                    ptr_next   = '0;
                    state_next = ST_EMIT;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_element_next   = tuple_reg[ptr_reg];
                    m_position_next  = POS_W'(ptr_reg);
                    m_last_next      = at_last;
                    m_exhausted_next = 1'b0;
                    if (at_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            ST_EXH: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_element_next   = '0;
                    m_position_next  = '0;
                    m_last_next      = 1'b1;
                    m_exhausted_next = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_N_ITEMS: begin
                    n_items_next  = cfg_wdata;
                    started_next  = 1'b0;
                    finished_next = 1'b0;
                end
                REG_TUPLE_LEN: begin
                    tuple_len_next = cfg_wdata;
                    started_next   = 1'b0;
                    finished_next  = 1'b0;
                end
                REG_MODE: begin
                    mode_next     = mode_t'(cfg_wdata[1:0]);
                    started_next  = 1'b0;
                    finished_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            n_items_reg   <= VAL_W'(4);
            tuple_len_reg <= VAL_W'(2);
            mode_reg      <= MODE_PERM;
            started_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            n_items_reg   <= n_items_next;
            tuple_len_reg <= tuple_len_next;
            mode_reg      <= mode_next;
            started_reg   <= started_next;
            finished_reg  <= finished_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tuple_reg       <= tuple_next;
        used_reg        <= used_next;
        ptr_reg         <= ptr_next;
        base_reg        <= base_next;
        m_element_reg   <= m_element_next;
        m_position_reg  <= m_position_next;
        m_last_reg      <= m_last_next;
        m_exhausted_reg <= m_exhausted_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_element   = m_element_reg;
    assign m_position  = m_position_reg;
    assign m_last      = m_last_reg;
    assign m_exhausted = m_exhausted_reg;

    assign exh_beat  = m_valid_reg && m_exhausted_reg;
    assign exh_ok    = m_last_reg && (m_element_reg == '0);
    assign elem_beat = m_valid_reg && !m_exhausted_reg;
    assign adv_exh   = s_fire && !s_restart && started_reg && finished_reg;

    `TENUM_ASSERT_IMPL(a_exh_shape, exh_beat, exh_ok, "bad exhausted transfer")
    `TENUM_ASSERT_IMPL(a_elem_nonzero, elem_beat, m_element_reg != '0, "zero tuple element")
    `TENUM_ASSERT_NEXT(a_repeat_exh, adv_exh, state_reg == ST_EXH, "repeat exhausted missing")

endmodule
